### rtl/core/pssh_pkg.sv
// Shared types and constants of the pssh box parser.
package pssh_pkg;

  localparam logic [31:0] BoxTypeReset = 32'h7073_7368;

  localparam logic [2:0] KindHdr  = 3'd0;
  localparam logic [2:0] KindSys  = 3'd1;
  localparam logic [2:0] KindKey  = 3'd2;
  localparam logic [2:0] KindData = 3'd3;
  localparam logic [2:0] KindIgn  = 3'd4;

  localparam logic [1:0] StatBusy  = 2'd0;
  localparam logic [1:0] StatDone  = 2'd1;
  localparam logic [1:0] StatType  = 2'd2;
  localparam logic [1:0] StatTrunc = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [3:0]  idx;
    logic [31:0] key_num;
    logic [7:0]  version;
    logic [23:0] flags;
    logic [1:0]  status;
  } res_t;

endpackage

### rtl/core/pssh_parse_core.sv
// Parse state and per-byte classification of the pssh box parser.
module pssh_parse_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [31:0]         box_type_i,
  output pssh_pkg::res_t      res_o
);

  typedef enum logic [3:0] {
    PhSize   = 4'd0,
    PhType   = 4'd1,
    PhHdr    = 4'd2,
    PhSysid  = 4'd3,
    PhKcount = 4'd4,
    PhKeyid  = 4'd5,
    PhDsize  = 4'd6,
    PhData   = 4'd7,
    PhDone   = 4'd8,
    PhErr    = 4'd9
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] word_q, word_d;
  logic [7:0]  ver_q, ver_d;
  logic [23:0] flags_q, flags_d;
  logic [31:0] keys_q, keys_d;
  logic [31:0] kctr_q, kctr_d;
  logic [31:0] data_q, data_d;
  logic [1:0]  err_q, err_d;

  logic [31:0] word_new;
  logic        word_end;
  logic        id_end;
  logic [3:0]  cnt_inc;

  assign word_new = {word_q[23:0], byte_i};
  assign word_end = (cnt_q == 4'd3);
  assign id_end   = (cnt_q == 4'd15);
  assign cnt_inc  = cnt_q + 4'd1;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    ver_d   = ver_q;
    flags_d = flags_q;
    keys_d  = keys_q;
    kctr_d  = kctr_q;
    data_d  = data_q;
    err_d   = err_q;
    res_o.kind    = pssh_pkg::KindHdr;
    res_o.value   = byte_i;
    res_o.idx     = 4'd0;
    res_o.key_num = 32'd0;

    unique case (phase_q)
      PhSize, PhType, PhHdr, PhKcount, PhDsize: begin
        word_d = word_new;
        cnt_d  = word_end ? 4'd0 : cnt_inc;
        if (word_end) begin
          word_d = 32'd0;
          unique case (phase_q)
            PhSize: phase_d = PhType;
            PhType: begin
              if (word_new != box_type_i) begin
                err_d   = pssh_pkg::StatType;
                phase_d = PhErr;
              end else begin
                phase_d = PhHdr;
              end
            end
            PhHdr: begin
              ver_d   = word_new[31:24];
              flags_d = word_new[23:0];
              phase_d = PhSysid;
            end
            PhKcount: begin
              keys_d  = word_new;
              kctr_d  = 32'd0;
              phase_d = (word_new == 32'd0) ? PhDsize : PhKeyid;
            end
            default: begin
              data_d  = word_new;
              phase_d = (word_new == 32'd0) ? PhDone : PhData;
            end
          endcase
        end
      end
      PhSysid: begin
        res_o.kind = pssh_pkg::KindSys;
        res_o.idx  = cnt_q;
        cnt_d      = id_end ? 4'd0 : cnt_inc;
        if (id_end) phase_d = (ver_q == 8'd1) ? PhKcount : PhDsize;
      end
      PhKeyid: begin
        res_o.kind    = pssh_pkg::KindKey;
        res_o.idx     = cnt_q;
        res_o.key_num = kctr_q;
        cnt_d         = id_end ? 4'd0 : cnt_inc;
        if (id_end) begin
          kctr_d = kctr_q + 32'd1;
          keys_d = keys_q - 32'd1;
          if (keys_q == 32'd1) phase_d = PhDsize;
        end
      end
      PhData: begin
        res_o.kind = pssh_pkg::KindData;
        data_d     = data_q - 32'd1;
        if (data_q == 32'd1) phase_d = PhDone;
      end
      default: res_o.kind = pssh_pkg::KindIgn;
    endcase

    res_o.version = ver_d;
    res_o.flags   = flags_d;
    if (err_d != pssh_pkg::StatBusy) res_o.status = err_d;
    else if (phase_d == PhDone)      res_o.status = pssh_pkg::StatDone;
    else if (last_i)                 res_o.status = pssh_pkg::StatTrunc;
    else                             res_o.status = pssh_pkg::StatBusy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSize;
      cnt_q   <= 4'd0;
      word_q  <= 32'd0;
      ver_q   <= 8'd0;
      flags_q <= 24'd0;
      keys_q  <= 32'd0;
      kctr_q  <= 32'd0;
      data_q  <= 32'd0;
      err_q   <= 2'd0;
    end else if (en_i) begin
      if (last_i) begin
        phase_q <= PhSize;
        cnt_q   <= 4'd0;
        word_q  <= 32'd0;
        ver_q   <= 8'd0;
        flags_q <= 24'd0;
        keys_q  <= 32'd0;
        kctr_q  <= 32'd0;
        data_q  <= 32'd0;
        err_q   <= 2'd0;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        word_q  <= word_d;
        ver_q   <= ver_d;
        flags_q <= flags_d;
        keys_q  <= keys_d;
        kctr_q  <= kctr_d;
        data_q  <= data_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

### rtl/core/pssh_box_parser.sv
// Top level of the pssh box parser: input register, parse core, result register.
// Accepts one box byte per cycle while in_ready_o is high and presents one
// classified result item per byte through the input register and then the result
// register, held back while that register is stalled. The input and result
// registers each take a new item whenever empty or the next stage can move, so the
// sustained rate is one item per clock when unstalled, bounded by the phase update.
// box_type may be rewritten only while no item is in flight.
module pssh_box_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  byte_kind_o,
  output logic [7:0]  byte_value_o,
  output logic [3:0]  id_byte_index_o,
  output logic [31:0] key_number_o,
  output logic [7:0]  box_version_o,
  output logic [23:0] box_flags_o,
  output logic [1:0]  parse_status_o
);

  logic [31:0]    box_type_q;
  logic           s1_valid_q;
  logic [7:0]     s1_byte_q;
  logic           s1_last_q;
  logic           out_valid_q;
  pssh_pkg::res_t res_d, res_q;
  logic           s2_ready;
  logic           adv;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign adv        = s1_valid_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_type_q <= pssh_pkg::BoxTypeReset;
    end else if (cfg_we_i) begin
      box_type_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s2_ready)   out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (adv) res_q <= res_d;
  end

  pssh_parse_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .byte_i     (s1_byte_q),
    .last_i     (s1_last_q),
    .box_type_i (box_type_q),
    .res_o      (res_d)
  );

  assign out_valid_o     = out_valid_q;
  assign byte_kind_o     = res_q.kind;
  assign byte_value_o    = res_q.value;
  assign id_byte_index_o = res_q.idx;
  assign key_number_o    = res_q.key_num;
  assign box_version_o   = res_q.version;
  assign box_flags_o     = res_q.flags;
  assign parse_status_o  = res_q.status;

endmodule

### rtl/core/pssh_box_parser_chk.sv
// Port-level checker of the pssh box parser, bound to the top level.
module pssh_box_parser_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  byte_kind_o,
  input logic [3:0]  id_byte_index_o,
  input logic [31:0] key_number_o,
  input logic [1:0]  parse_status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result stage");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o != pssh_pkg::KindSys && byte_kind_o != pssh_pkg::KindKey
    |-> id_byte_index_o == 4'd0)
    else $error("id index set outside id bytes");

  a_keynum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o != pssh_pkg::KindKey |-> key_number_o == 32'd0)
    else $error("key number set outside key id bytes");

  a_type_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_status_o == pssh_pkg::StatType
    |-> byte_kind_o == pssh_pkg::KindHdr || byte_kind_o == pssh_pkg::KindIgn)
    else $error("payload byte reported after type mismatch");

endmodule

bind pssh_box_parser pssh_box_parser_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .byte_kind_o     (byte_kind_o),
  .id_byte_index_o (id_byte_index_o),
  .key_number_o    (key_number_o),
  .parse_status_o  (parse_status_o)
);

### tb/sv/pssh_box_parser_test.sv
// Testbench for the pssh box parser: byte stream driver, result checker, box type sweep.
`timescale 1ns / 100ps

module pssh_box_parser_test;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 400;

  typedef enum logic [3:0] {
    PhSize, PhType, PhHdr, PhSysId, PhKeyCount, PhKeyId, PhDataSize, PhData, PhDone, PhError
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  byte_kind_o;
  logic [7:0]  byte_value_o;
  logic [3:0]  id_byte_index_o;
  logic [31:0] key_number_o;
  logic [7:0]  box_version_o;
  logic [23:0] box_flags_o;
  logic [1:0]  parse_status_o;

  pssh_box_parser DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .byte_kind_o     (byte_kind_o),
    .byte_value_o    (byte_value_o),
    .id_byte_index_o (id_byte_index_o),
    .key_number_o    (key_number_o),
    .box_version_o   (box_version_o),
    .box_flags_o     (box_flags_o),
    .parse_status_o  (parse_status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  byte_item_t     byte_queue[$];
  pssh_pkg::res_t pending_results[$];
  logic [7:0]     box_bytes[$];
  byte_item_t     next_item;
  pssh_pkg::res_t got_item;
  pssh_pkg::res_t want_item;
  int             useful_bytes = 0;
  int             mismatches = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             hold_requests = 0;
  int             holds_seen = 0;
  int             hold_left = 0;
  int             stall_cycles = 0;

  // Parser state as seen by the byte classifier
  logic [31:0]  expected_type;
  parse_phase_e parse_phase;
  logic [3:0]   field_cnt;
  logic [31:0]  word_acc;
  logic [7:0]   hdr_version;
  logic [23:0]  hdr_flags;
  logic [31:0]  keys_left;
  logic [31:0]  key_ordinal;
  logic [31:0]  data_left;
  logic [1:0]   parse_err;

  function automatic void restart_parse();
    parse_phase = PhSize;
    field_cnt   = '0;
    word_acc    = '0;
    hdr_version = '0;
    hdr_flags   = '0;
    keys_left   = '0;
    key_ordinal = '0;
    data_left   = '0;
    parse_err   = pssh_pkg::StatBusy;
  endfunction

  function automatic pssh_pkg::res_t classify_byte(input logic [7:0] b, input logic is_last);
    pssh_pkg::res_t r;
    logic word_done;
    r = '0;
    r.kind = pssh_pkg::KindHdr;
    r.value = b;
    word_done = 1'b0;
    case (parse_phase)
      PhSize, PhType, PhHdr, PhKeyCount, PhDataSize: begin
        word_acc = {word_acc[23:0], b};
        word_done = (field_cnt == 4'd3);
        field_cnt = word_done ? 4'd0 : field_cnt + 4'd1;
      end
      default: ;
    endcase
    case (parse_phase)
      PhSize: if (word_done) begin
        word_acc = '0;
        parse_phase = PhType;
      end
      PhType: if (word_done) begin
        if (word_acc != expected_type) begin
          parse_err = pssh_pkg::StatType;
          parse_phase = PhError;
        end else begin
          parse_phase = PhHdr;
        end
        word_acc = '0;
      end
      PhHdr: if (word_done) begin
        hdr_version = word_acc[31:24];
        hdr_flags = word_acc[23:0];
        word_acc = '0;
        parse_phase = PhSysId;
      end
      PhSysId: begin
        r.kind = pssh_pkg::KindSys;
        r.idx = field_cnt;
        if (field_cnt == 4'd15) begin
          field_cnt = '0;
          parse_phase = (hdr_version == 8'd1) ? PhKeyCount : PhDataSize;
        end else begin
          field_cnt = field_cnt + 4'd1;
        end
      end
      PhKeyCount: if (word_done) begin
        keys_left = word_acc;
        word_acc = '0;
        key_ordinal = '0;
        parse_phase = (keys_left == 0) ? PhDataSize : PhKeyId;
      end
      PhKeyId: begin
        r.kind = pssh_pkg::KindKey;
        r.idx = field_cnt;
        r.key_num = key_ordinal;
        if (field_cnt == 4'd15) begin
          field_cnt = '0;
          key_ordinal = key_ordinal + 32'd1;
          keys_left = keys_left - 32'd1;
          if (keys_left == 0) parse_phase = PhDataSize;
        end else begin
          field_cnt = field_cnt + 4'd1;
        end
      end
      PhDataSize: if (word_done) begin
        data_left = word_acc;
        word_acc = '0;
        parse_phase = (data_left == 0) ? PhDone : PhData;
      end
      PhData: begin
        r.kind = pssh_pkg::KindData;
        data_left = data_left - 32'd1;
        if (data_left == 0) parse_phase = PhDone;
      end
      default: r.kind = pssh_pkg::KindIgn;
    endcase
    r.status = parse_err;
    if (r.status == pssh_pkg::StatBusy && parse_phase == PhDone) r.status = pssh_pkg::StatDone;
    if (r.status == pssh_pkg::StatBusy && is_last) r.status = pssh_pkg::StatTrunc;
    r.version = hdr_version;
    r.flags = hdr_flags;
    if (is_last) restart_parse();
    return r;
  endfunction

  // Driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        pending_results.push_back(classify_byte(data_byte_i, last_byte_i));
      if (!in_valid_i || in_ready_o) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = byte_queue.pop_front();
          data_byte_i <= next_item.data;
          last_byte_i <= next_item.last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor and receiver backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_item = '{byte_kind_o, byte_value_o, id_byte_index_o, key_number_o,
                     box_version_o, box_flags_o, parse_status_o};
        if (pending_results.size() == 0) begin
          $error("result item with none expected: kind %0d value 0x%0h",
                 byte_kind_o, byte_value_o);
          mismatches++;
        end else begin
          want_item = pending_results.pop_front();
          check_field("byte_kind", want_item.kind, got_item.kind);
          check_field("byte_value", want_item.value, got_item.value);
          check_field("id_byte_index", want_item.idx, got_item.idx);
          check_field("key_number", want_item.key_num, got_item.key_num);
          check_field("box_version", want_item.version, got_item.version);
          check_field("box_flags", want_item.flags, got_item.flags);
          check_field("parse_status", want_item.status, got_item.status);
        end
      end
      if (holds_seen != hold_requests) begin
        holds_seen <= hold_requests;
        hold_left <= HoldCycles;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic add_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) box_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) box_bytes.push_back(8'($urandom()));
  endtask

  task automatic flush_box();
    byte_item_t item;
    foreach (box_bytes[i]) begin
      item.data = box_bytes[i];
      item.last = (i == box_bytes.size() - 1);
      byte_queue.push_back(item);
    end
    box_bytes.delete();
  endtask

  // One box; counts above the limits leave the box cut short by its final byte
  task automatic queue_box(input logic [31:0] typ, input logic [7:0] ver,
                           input logic [31:0] nkeys, input logic [31:0] dsize,
                           input int cut, input int extra);
    int nk;
    int nd;
    logic [23:0] flg;
    nk = (nkeys > 4) ? 4 : int'(nkeys);
    nd = (dsize > 40) ? 40 : int'(dsize);
    flg = 24'($urandom());
    box_bytes.delete();
    add_word($urandom());
    add_word(typ);
    add_word({ver, flg});
    add_random(16);
    if (ver == 8'd1) begin
      add_word(nkeys);
      add_random(16 * nk);
    end
    add_word(dsize);
    add_random(nd);
    add_random(extra);
    if (cut >= 0)
      while (box_bytes.size() > cut + 1) void'(box_bytes.pop_back());
    useful_bytes += box_bytes.size();
    flush_box();
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_box_type(input logic [31:0] v);
    wait_drained();
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    expected_type = v;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int target);
    int stop;
    int r;
    int n;
    logic [31:0] typ;
    logic [7:0]  ver;
    logic [31:0] nkeys;
    logic [31:0] dsize;
    int cut;
    int extra;
    stop = useful_bytes + target;
    while (useful_bytes < stop) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise: a few raw bytes, sometimes closing the box
        n = $urandom_range(1, 6);
        add_random(n);
        flush_box();
        if ($urandom_range(0, 3) != 0) byte_queue[byte_queue.size() - 1].last = 1'b0;
        useful_bytes += n;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) typ = $urandom();
        else if (r < 3) typ = expected_type ^ (32'd1 << $urandom_range(0, 31));
        else typ = expected_type;
        r = $urandom_range(0, 9);
        ver = (r < 4) ? 8'd0 : (r < 9) ? 8'd1 : 8'($urandom());
        nkeys = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 3);
        r = $urandom_range(0, 19);
        dsize = (r < 4) ? 32'd0 : (r < 19) ? $urandom_range(1, 24) : $urandom();
        cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 60) : -1;
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        queue_box(typ, ver, nkeys, dsize, cut, extra);
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    expected_type = pssh_pkg::BoxTypeReset;
    restart_parse();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle_pct = 8;
    recv_idle_pct = 61;

    // lone byte that is also the last one
    box_bytes.push_back(8'h00);
    flush_box();
    // wrong type caught on its fourth byte, which also ends the box
    add_word(32'hFFFF_FFFF);
    add_word(~expected_type);
    flush_box();
    // right type, box ends on the version byte
    add_word(32'h0000_0000);
    add_word(expected_type);
    box_bytes.push_back(8'hFF);
    flush_box();
    useful_bytes += 18;

    hold_requests++;
    run_random(700);

    write_box_type(32'hFFFF_FFFF);
    send_idle_pct = 61;
    recv_idle_pct = 8;
    run_random(600);

    write_box_type(32'h0000_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300);

    write_box_type($urandom());
    run_random(120);

    write_box_type(pssh_pkg::BoxTypeReset);
    run_random(80);

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/core/pssh_pkg.sv
rtl/core/pssh_parse_core.sv
rtl/core/pssh_box_parser.sv
rtl/core/pssh_box_parser_chk.sv
tb/sv/pssh_box_parser_test.sv
